FILE: hw/rtl/scc_pkg.sv
// Shared constants and types for the condensation edge counter.
package scc_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_EDGES    = 1024;
    localparam int VW = $clog2(MAX_VERTICES);      // vertex index width
    localparam int CW = $clog2(MAX_VERTICES) + 1;  // vertex count width
    localparam int EW = $clog2(MAX_EDGES);         // edge address width
    localparam int TW = $clog2(MAX_EDGES) + 1;     // edge count width
    localparam int PW = 12;                        // pair count width

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_F_NEXT = 13'b0000000000010,
        ST_W_RD   = 13'b0000000000100,
        ST_W_EV   = 13'b0000000001000,
        ST_W_POP  = 13'b0000000010000,
        ST_R_RD   = 13'b0000000100000,
        ST_R_CHK  = 13'b0000001000000,
        ST_P_RD   = 13'b0000010000000,
        ST_P_LS   = 13'b0000100000000,
        ST_P_LT   = 13'b0001000000000,
        ST_P_ROW  = 13'b0010000000000,
        ST_P_CHK  = 13'b0100000000000,
        ST_DONE   = 13'b1000000000000
    } scc_state_t;

endpackage

FILE: hw/rtl/scc_condensation_edge_count.sv
// Strongly connected component condensation edge counter, top level.
//
// Requests with tuser = 0 add one directed edge (1-based vertices) to a 1024-entry
// edge store, one request per cycle while idle. A request with tuser = 1 runs
// Kosaraju's two-pass search and returns one result: the number of distinct ordered
// component pairs joined by an edge, the component count and two sticky error flags;
// the edge store and flags are then emptied. The search walks the edge store itself
// instead of building an adjacency list: each visited vertex scans the whole store
// once per pass, and the pair count scans it once more, one stored edge at a time
// through the single read port of the edge memory. Input is held off during a compute.
// Edges with vertex 0 or above the effective vertex count, and edges past capacity,
// are dropped and flagged.
module scc_condensation_edge_count (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,      // vertex_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,        // [6:0] edge_from, [13:7] edge_to, zero fill
    input  logic        s_tuser,        // action: 0 add edge, 1 compute
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // [11:0] condensed_edge_count,
                                        // [18:12] component_count,
                                        // [19] capacity_overflow, [20] bad_vertex
);
    import scc_pkg::*;

    scc_state_t state_reg, state_next;

    logic [6:0]   vcount_reg;
    logic [CW-1:0] n_reg, n_next, neff;
    logic [CW-1:0] vtx_reg, vtx_next;
    logic [VW-1:0] top_reg, top_next;
    logic [TW-1:0] cur_reg, cur_next;
    logic [CW-1:0] sp_reg, sp_next;
    logic [CW-1:0] ord_reg, ord_next;
    logic [CW-1:0] comps_reg, comps_next;
    logic [PW-1:0] pairs_reg, pairs_next;
    logic          rev_reg, rev_next;
    logic [MAX_VERTICES-1:0] visited_reg, visited_next;
    logic [MAX_VERTICES-1:0] labeled_reg, labeled_next;
    logic [MAX_VERTICES-1:0] rowv_reg, rowv_next;
    logic [VW-1:0] ls_reg, ls_next;
    logic [TW-1:0] total_reg, total_next;
    logic          ovf_reg, ovf_next, bad_reg, bad_next;
    logic          m_valid_reg, m_valid_next;
    logic [23:0]   m_data_reg, m_data_next;

    // Memories with registered read data.
    logic [2*VW-1:0] edge_mem [MAX_EDGES];
    logic [2*VW-1:0] edge_q, edge_wdata;
    logic [EW-1:0]   edge_waddr, edge_raddr;
    logic            edge_we;

    logic [VW+TW-1:0] stk_mem [MAX_VERTICES];
    logic [VW+TW-1:0] stk_q, stk_wdata;
    logic [VW-1:0]    stk_waddr, stk_raddr;
    logic             stk_we;

    logic [VW-1:0] fin_mem [MAX_VERTICES];
    logic [VW-1:0] fin_q, fin_wdata, fin_waddr, fin_raddr;
    logic          fin_we;

    logic [CW-1:0] lab_mem [MAX_VERTICES];
    logic [CW-1:0] lab_q, lab_wdata;
    logic [VW-1:0] lab_waddr, lab_raddr;
    logic          lab_we;

    logic [MAX_VERTICES-1:0] pair_mem [MAX_VERTICES];
    logic [MAX_VERTICES-1:0] pair_q, pair_wdata, row;
    logic [VW-1:0]           pair_waddr, pair_raddr;
    logic                    pair_we;

    always_ff @(posedge aclk) begin
        if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
        edge_q <= edge_mem[edge_raddr];
        if (stk_we) stk_mem[stk_waddr] <= stk_wdata;
        stk_q <= stk_mem[stk_raddr];
        if (fin_we) fin_mem[fin_waddr] <= fin_wdata;
        fin_q <= fin_mem[fin_raddr];
        if (lab_we) lab_mem[lab_waddr] <= lab_wdata;
        lab_q <= lab_mem[lab_raddr];
        if (pair_we) pair_mem[pair_waddr] <= pair_wdata;
        pair_q <= pair_mem[pair_raddr];
    end

    logic [6:0]    in_from, in_to;
    logic [VW-1:0] e_src, e_tgt, key, nbr, lt;
    logic          hit, seen, in_ok;
    logic [CW-1:0] sp_m2, lab_m1;

    assign in_from = s_tdata[6:0];
    assign in_to   = s_tdata[13:7];
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // The effective vertex count is the register clamped to 1..MAX_VERTICES.
    always_comb begin
        if (vcount_reg == 7'd0) begin
            neff = CW'(1);
        end else if (vcount_reg > 7'(MAX_VERTICES)) begin
            neff = CW'(MAX_VERTICES);
        end else begin
            neff = CW'(vcount_reg);
        end
    end

    assign in_ok = (in_from != 7'd0) && (in_to != 7'd0) &&
                   (in_from <= 7'(neff)) && (in_to <= 7'(neff));
    assign e_src = edge_q[VW-1:0];
    assign e_tgt = edge_q[2*VW-1:VW];
    assign key   = rev_reg ? e_tgt : e_src;
    assign nbr   = rev_reg ? e_src : e_tgt;
    assign hit   = (key == top_reg) && (CW'(e_src) < n_reg) && (CW'(e_tgt) < n_reg);
    assign seen  = rev_reg ? labeled_reg[nbr] : visited_reg[nbr];
    assign sp_m2 = sp_reg - CW'(2);
    assign lab_m1 = lab_q - CW'(1);
    assign lt    = lab_m1[VW-1:0];
    assign row   = rowv_reg[ls_reg] ? pair_q : '0;

    always_comb begin
        state_next = state_reg;
        n_next = n_reg;        vtx_next = vtx_reg;     top_next = top_reg;
        cur_next = cur_reg;    sp_next = sp_reg;       ord_next = ord_reg;
        comps_next = comps_reg; pairs_next = pairs_reg; rev_next = rev_reg;
        visited_next = visited_reg; labeled_next = labeled_reg; rowv_next = rowv_reg;
        ls_next = ls_reg;      total_next = total_reg;
        ovf_next = ovf_reg;    bad_next = bad_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next = m_data_reg;

        edge_we = 1'b0;  edge_waddr = total_reg[EW-1:0];
        edge_wdata = {VW'(in_to - 7'd1), VW'(in_from - 7'd1)};
        edge_raddr = cur_reg[EW-1:0];
        stk_we = 1'b0;   stk_waddr = sp_reg[VW-1:0] - VW'(1);
        stk_wdata = {top_reg, cur_reg + TW'(1)};
        stk_raddr = sp_m2[VW-1:0];
        fin_we = 1'b0;   fin_waddr = ord_reg[VW-1:0]; fin_wdata = top_reg;
        fin_raddr = VW'(vtx_reg - CW'(1));
        lab_we = 1'b0;   lab_waddr = nbr; lab_wdata = comps_reg; lab_raddr = e_src;
        pair_we = 1'b0;  pair_waddr = ls_reg; pair_raddr = ls_reg;
        pair_wdata = row | (MAX_VERTICES'(1) << top_reg);

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tuser) begin
                        if (!in_ok) begin
                            bad_next = 1'b1;
                        end else if (total_reg >= TW'(MAX_EDGES)) begin
                            ovf_next = 1'b1;
                        end else begin
                            edge_we = 1'b1;
                            total_next = total_reg + TW'(1);
                        end
                    end else begin
                        n_next = neff;
                        vtx_next = '0; ord_next = '0; comps_next = '0;
                        pairs_next = '0; rev_next = 1'b0;
                        visited_next = '0; labeled_next = '0; rowv_next = '0;
                        state_next = ST_F_NEXT;
                    end
                end
            end
            ST_F_NEXT: begin
                if (vtx_reg == n_reg) begin
                    rev_next = 1'b1;
                    vtx_next = ord_reg;
                    state_next = ST_R_RD;
                end else begin
                    vtx_next = vtx_reg + CW'(1);
                    if (!visited_reg[vtx_reg[VW-1:0]]) begin
                        visited_next[vtx_reg[VW-1:0]] = 1'b1;
                        top_next = vtx_reg[VW-1:0];
                        cur_next = '0;
                        sp_next = CW'(1);
                        state_next = ST_W_RD;
                    end
                end
            end
            ST_W_RD: begin
                if (cur_reg == total_reg) begin
                    if (!rev_reg && ord_reg < CW'(MAX_VERTICES)) begin
                        fin_we = 1'b1;
                        ord_next = ord_reg + CW'(1);
                    end
                    if (sp_reg == CW'(1)) begin
                        state_next = rev_reg ? ST_R_RD : ST_F_NEXT;
                    end else begin
                        sp_next = sp_reg - CW'(1);
                        state_next = ST_W_POP;
                    end
                end else begin
                    state_next = ST_W_EV;
                end
            end
            ST_W_EV: begin
                cur_next = cur_reg + TW'(1);
                state_next = ST_W_RD;
                if (hit && !seen && sp_reg < CW'(MAX_VERTICES)) begin
                    if (rev_reg) begin
                        labeled_next[nbr] = 1'b1;
                        lab_we = 1'b1;
                    end else begin
                        visited_next[nbr] = 1'b1;
                    end
                    stk_we = 1'b1;
                    top_next = nbr;
                    cur_next = '0;
                    sp_next = sp_reg + CW'(1);
                end
            end
            ST_W_POP: begin
                top_next = stk_q[VW+TW-1:TW];
                cur_next = stk_q[TW-1:0];
                state_next = ST_W_RD;
            end
            ST_R_RD: begin
                if (vtx_reg == '0) begin
                    cur_next = '0;
                    state_next = ST_P_RD;
                end else begin
                    vtx_next = vtx_reg - CW'(1);
                    state_next = ST_R_CHK;
                end
            end
            ST_R_CHK: begin
                state_next = ST_R_RD;
                if (!labeled_reg[fin_q]) begin
                    comps_next = comps_reg + CW'(1);
                    labeled_next[fin_q] = 1'b1;
                    lab_we = 1'b1;
                    lab_waddr = fin_q;
                    lab_wdata = comps_reg + CW'(1);
                    top_next = fin_q;
                    cur_next = '0;
                    sp_next = CW'(1);
                    state_next = ST_W_RD;
                end
            end
            ST_P_RD: begin
                state_next = (cur_reg == total_reg) ? ST_DONE : ST_P_LS;
            end
            ST_P_LS: begin
                cur_next = cur_reg + TW'(1);
                state_next = ST_P_RD;
                if (CW'(e_src) < n_reg && CW'(e_tgt) < n_reg) begin
                    top_next = e_tgt;
                    state_next = ST_P_LT;
                end
            end
            ST_P_LT: begin
                ls_next = lt;
                lab_raddr = top_reg;
                state_next = ST_P_ROW;
            end
            ST_P_ROW: begin
                pair_raddr = ls_reg;
                top_next = lt;
                state_next = (lt != ls_reg) ? ST_P_CHK : ST_P_RD;
            end
            ST_P_CHK: begin
                if (!row[top_reg]) begin
                    pair_we = 1'b1;
                    rowv_next[ls_reg] = 1'b1;
                    pairs_next = pairs_reg + PW'(1);
                end
                state_next = ST_P_RD;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next = {3'b000, bad_reg, ovf_reg, comps_reg, pairs_reg};
                    total_next = '0;
                    ovf_next = 1'b0;
                    bad_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            vcount_reg <= 7'(MAX_VERTICES);
            total_reg <= '0;
            ovf_reg <= 1'b0;
            bad_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) vcount_reg <= cfg_wdata;
            total_reg <= total_next;
            ovf_reg <= ovf_next;
            bad_reg <= bad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg <= n_next;         vtx_reg <= vtx_next;     top_reg <= top_next;
        cur_reg <= cur_next;     sp_reg <= sp_next;       ord_reg <= ord_next;
        comps_reg <= comps_next; pairs_reg <= pairs_next; rev_reg <= rev_next;
        visited_reg <= visited_next; labeled_reg <= labeled_next;
        rowv_reg <= rowv_next;   ls_reg <= ls_next;       m_data_reg <= m_data_next;
    end

    // The walk stack never runs empty or past its depth while a walk is active.
    a_stack_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_W_RD || state_reg == ST_W_EV) |->
        (sp_reg != '0 && sp_reg <= CW'(MAX_VERTICES)))
        else $error("walk stack depth out of range");

    // The edge store never holds more than its capacity.
    a_store_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        total_reg <= TW'(MAX_EDGES))
        else $error("edge store count beyond capacity");

    // Handing off a result presents it and empties the edge store.
    a_result_handoff: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && (!m_valid_reg || m_tready)) |=>
        (m_valid_reg && total_reg == '0 && state_reg == ST_IDLE))
        else $error("result not presented after compute");

endmodule
